### sv/q2e_pkg.sv
// Package for the quaternion to Euler angle converter.
// Internal word widths, arctangent table and stage records shared by all modules.
// No dependencies.
package q2e_pkg;

  // Internal fixed point: products and sums in Q.28, angles in Q.24
  localparam int QI        = 28;
  localparam int QA        = 24;
  localparam int PW        = 32;   // scaled product, |p| <= 2^30
  localparam int VW        = 34;   // quadratic sums, |v| <= 2^32
  localparam int CX        = 36;   // CORDIC vector, headroom for gain
  localparam int CZ        = 28;   // CORDIC angle accumulator
  localparam int SQ_BITS   = 29;   // root bits, isqrt(2^56) = 2^28
  localparam int RW        = 57;   // square root radicand
  localparam int TABLE_LEN = 30;

  localparam longint HALF_PI_QA  = 64'sd26353589;
  localparam longint PI_Q29      = 64'sd1686629713;
  localparam longint HALF_PI_Q29 = 64'sd843314857;

  // atan(2^-i) in Q.24
  localparam logic [CZ-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    28'd13176795, 28'd7778716, 28'd4110060, 28'd2086331, 28'd1047214,
    28'd524117,   28'd262123,  28'd131069,  28'd65536,   28'd32768,
    28'd16384,    28'd8192,    28'd4096,    28'd2048,    28'd1024,
    28'd512,      28'd256,     28'd128,     28'd64,      28'd32,
    28'd16,       28'd8,       28'd4,       28'd2,       28'd1,
    28'd0,        28'd0,       28'd0,       28'd0,       28'd0
  };

  // One CORDIC cell's view of the vector
  typedef struct packed {
    logic signed [CX-1:0] x;
    logic signed [CX-1:0] y;
    logic signed [CZ-1:0] z;
    logic                 zero;
  } cvec_t;

  // Sums and pitch flags carried alongside the square root
  typedef struct packed {
    logic signed [VW-1:0] sr;
    logic signed [VW-1:0] cr;
    logic signed [VW-1:0] sy;
    logic signed [VW-1:0] cy;
    logic signed [VW-1:0] s;
    logic                 clamp_pos;
    logic                 clamp_neg;
  } side_t;

endpackage

### sv/q2e_sqrt_cell.sv
// One bit of a pipelined restoring integer square root.
// Depends on q2e_pkg.
module q2e_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [q2e_pkg::RW-1:0]      rem_i,
  input  logic [q2e_pkg::SQ_BITS-1:0] root_i,
  output logic [q2e_pkg::RW-1:0]      rem_o,
  output logic [q2e_pkg::SQ_BITS-1:0] root_o
);
  import q2e_pkg::*;

  logic [RW+1:0]      test;
  logic [RW-1:0]      rem_nxt, rem_r;
  logic [SQ_BITS-1:0] root_nxt, root_r;

  // (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
  always_comb begin
    test = ((RW+2)'(root_i) << (BIT + 1)) + ((RW+2)'(1) << (2 * BIT));
    if ((RW+2)'(rem_i) >= test) begin
      rem_nxt  = rem_i - RW'(test);
      root_nxt = root_i | (SQ_BITS'(1) << BIT);
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

### sv/q2e_cordic_cell.sv
// One vectoring CORDIC iteration with its output register.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  q2e_pkg::cvec_t vec_i,
  output q2e_pkg::cvec_t vec_o
);
  import q2e_pkg::*;

  logic signed [CX-1:0] xs, ys;
  cvec_t vec_nxt, vec_r;

  // rotate towards the x axis
  always_comb begin
    xs = vec_i.x >>> SHIFT;
    ys = vec_i.y >>> SHIFT;
    vec_nxt.zero = vec_i.zero;
    if (!vec_i.y[CX-1]) begin
      vec_nxt.x = vec_i.x + ys;
      vec_nxt.y = vec_i.y - xs;
      vec_nxt.z = vec_i.z + $signed(ATAN_TAB[SHIFT]);
    end else begin
      vec_nxt.x = vec_i.x - ys;
      vec_nxt.y = vec_i.y + xs;
      vec_nxt.z = vec_i.z - $signed(ATAN_TAB[SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) vec_r <= vec_nxt;
  end

  assign vec_o = vec_r;

endmodule

### sv/q2e_cordic.sv
// Four-quadrant arctangent: quadrant fold stage then a row of CORDIC cells.
// Depends on q2e_pkg and q2e_cordic_cell.
module q2e_cordic #(
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [q2e_pkg::VW-1:0]   y_i,
  input  logic signed [q2e_pkg::VW-1:0]   x_i,
  output logic signed [q2e_pkg::CZ-1:0]   z_o
);
  import q2e_pkg::*;

  logic signed [CX-1:0] xe, ye;
  cvec_t pre_nxt, pre_r;
  cvec_t chain [0:STEPS];

  // fold the left half plane by a quarter turn
  always_comb begin
    xe = CX'(x_i);
    ye = CX'(y_i);
    pre_nxt.zero = (x_i == '0) && (y_i == '0);
    pre_nxt.x = xe;
    pre_nxt.y = ye;
    pre_nxt.z = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        pre_nxt.z = CZ'(HALF_PI_QA);
        pre_nxt.x = ye;
        pre_nxt.y = -xe;
      end else begin
        pre_nxt.z = -CZ'(HALF_PI_QA);
        pre_nxt.x = -ye;
        pre_nxt.y = xe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) pre_r <= pre_nxt;
  end

  assign chain[0] = pre_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    q2e_cordic_cell #(.SHIFT(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .vec_i (chain[i]),
      .vec_o (chain[i+1])
    );
  end

  // atan2(0, 0) is defined as zero
  assign z_o = chain[STEPS].zero ? '0 : chain[STEPS].z;

endmodule

### sv/quaternion_to_euler.sv
// Top level: quaternion to ZYX Euler angles (roll, pitch, yaw).
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic.
//
// Usage:
//   in_*  : one quaternion word per handshake, w, x, y, z in signed
//           Q2.(INPUT_WIDTH-2), packed from the lowest bit up.
//   out_* : roll, yaw in signed Q3.(ANGLE_WIDTH-3), pitch in Q2.(ANGLE_WIDTH-3);
//           out_tuser flags a clamped pitch (arcsine argument at magnitude one).
//   Throughput is one word per cycle unless stalled. The stages, in order:
//   multiply, sum, square, radicand, 29 square root cells, a quadrant fold
//   stage, one cell per CORDIC step and the output register.
//   The whole pipeline advances together; it stalls only while a finished
//   word sits in the output register and out_tready is low, and then
//   in_tready drops in the same cycle. Nothing is lost across a stall.
//   Reset clears the valid bits only; data registers are not reset.
module quaternion_to_euler #(
  parameter int INPUT_WIDTH  = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // w, x, y, z (INPUT_WIDTH bits each), zero padded to bytes
  input  logic [((4*INPUT_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // roll (ANGLE_WIDTH), pitch (ANGLE_WIDTH-1), yaw (ANGLE_WIDTH), zero padded
  output logic [((3*ANGLE_WIDTH-1+7)/8)*8-1:0] out_tdata,
  // pitch_clamped
  output logic [0:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);
  import q2e_pkg::*;

  localparam int IW   = INPUT_WIDTH;
  localparam int AW   = ANGLE_WIDTH;
  localparam int OW   = ((3*AW-1+7)/8)*8;
  localparam int LAT  = CORDIC_STEPS + SQ_BITS + 6;
  localparam int SIDE = SQ_BITS + 2;
  localparam int PSH  = 2*(IW-2) - QI;
  localparam int PSHR = (PSH > 0) ? PSH : 0;
  localparam int PSHL = (PSH < 0) ? -PSH : 0;
  localparam int OSH  = QA - (AW-3);
  localparam int OSHR = (OSH > 0) ? OSH : 0;
  localparam int OSHL = (OSH < 0) ? -OSH : 0;
  localparam longint RND_O = (longint'(1) << OSHR) >> 1;
  localparam int SH2  = 32 - AW;
  localparam longint RND2  = (longint'(1) << SH2) >> 1;
  localparam longint PI_O  = (PI_Q29 + RND2) >>> SH2;
  localparam longint HPI_O = (HALF_PI_Q29 + RND2) >>> SH2;
  localparam logic signed [VW-1:0] ONE = VW'(longint'(1) << QI);

  // scale a raw product to Q.28 with a floor shift
  function automatic logic signed [PW-1:0] scale(input logic signed [2*IW-1:0] p);
    logic signed [63:0] e;
    e = 64'(p);
    return PW'((e >>> PSHR) <<< PSHL);
  endfunction

  // round a Q.24 angle to the output format and saturate to +-lim
  function automatic logic signed [39:0] to_out(input logic signed [CZ-1:0] z,
                                                input longint lim);
    logic signed [39:0] r;
    r = ((40'(z) + 40'(RND_O)) >>> OSHR) <<< OSHL;
    if (r > 40'(lim)) r = 40'(lim);
    if (r < -40'(lim)) r = -40'(lim);
    return r;
  endfunction

  logic en;
  logic [LAT-1:0] vld_r, vld_nxt;

  // global advance: hold only while the output word waits
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: products
  logic signed [IW-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  assign qw = $signed(in_tdata[IW-1:0]);
  assign qx = $signed(in_tdata[2*IW-1:IW]);
  assign qy = $signed(in_tdata[3*IW-1:2*IW]);
  assign qz = $signed(in_tdata[4*IW-1:3*IW]);

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= scale(qw * qx);
      yz_r <= scale(qy * qz);
      xx_r <= scale(qx * qx);
      yy_r <= scale(qy * qy);
      wz_r <= scale(qw * qz);
      xy_r <= scale(qx * qy);
      zz_r <= scale(qz * qz);
      wy_r <= scale(qw * qy);
      zx_r <= scale(qz * qx);
    end
  end

  // stage 2: quadratic sums
  side_t sum_nxt, sum_r;

  always_comb begin
    sum_nxt.sr = (VW'(wx_r) + VW'(yz_r)) <<< 1;
    sum_nxt.cr = ONE - ((VW'(xx_r) + VW'(yy_r)) <<< 1);
    sum_nxt.sy = (VW'(wz_r) + VW'(xy_r)) <<< 1;
    sum_nxt.cy = ONE - ((VW'(yy_r) + VW'(zz_r)) <<< 1);
    sum_nxt.s  = (VW'(wy_r) - VW'(zx_r)) <<< 1;
    sum_nxt.clamp_pos = 1'b0;
    sum_nxt.clamp_neg = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) sum_r <= sum_nxt;
  end

  // stage 3: clamp test and s^2; stage 4: radicand 1 - s^2
  side_t side_r [0:SIDE-1];
  side_t side_nxt;
  logic signed [QI:0] s_nar;
  logic [2*QI-1:0] sq_r;
  logic [RW-1:0]   rem_r;

  always_comb begin
    side_nxt = sum_r;
    side_nxt.clamp_pos = (sum_r.s >= ONE);
    side_nxt.clamp_neg = (sum_r.s <= -ONE);
    s_nar = sum_r.s[QI:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= (2*QI)'(s_nar * s_nar);
      rem_r <= (RW'(1) << (2*QI)) - RW'(sq_r);
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE; i++) side_r[i] <= side_r[i-1];
    end
  end

  // square root row
  logic [RW-1:0]      rem_w  [0:SQ_BITS];
  logic [SQ_BITS-1:0] root_w [0:SQ_BITS];

  assign rem_w[0]  = rem_r;
  assign root_w[0] = '0;

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    q2e_sqrt_cell #(.BIT(SQ_BITS-1-j)) u_sqrt (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem_w[j]),
      .root_i (root_w[j]),
      .rem_o  (rem_w[j+1]),
      .root_o (root_w[j+1])
    );
  end

  // three arctangent rows
  logic signed [CZ-1:0] roll_z, pitch_z, yaw_z;
  logic signed [VW-1:0] pitch_x;

  assign pitch_x = $signed(VW'(root_w[SQ_BITS]));

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk (clk), .en (en),
    .y_i (side_r[SIDE-1].sr), .x_i (side_r[SIDE-1].cr), .z_o (roll_z)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk (clk), .en (en),
    .y_i (side_r[SIDE-1].s), .x_i (pitch_x), .z_o (pitch_z)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk (clk), .en (en),
    .y_i (side_r[SIDE-1].sy), .x_i (side_r[SIDE-1].cy), .z_o (yaw_z)
  );

  // clamp flags follow the CORDIC rows
  logic [1:0] clf_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      clf_r[0] <= {side_r[SIDE-1].clamp_pos, side_r[SIDE-1].clamp_neg};
      for (int i = 1; i <= CORDIC_STEPS; i++) clf_r[i] <= clf_r[i-1];
    end
  end

  // output register: round, saturate, apply pitch clamp
  logic signed [AW-1:0] roll_r, yaw_r, roll_nxt, yaw_nxt;
  logic signed [AW-2:0] pitch_r, pitch_nxt;
  logic                 clamp_r, clamp_nxt;
  logic signed [39:0]   pr;

  always_comb begin
    roll_nxt  = AW'(to_out(roll_z, PI_O));
    yaw_nxt   = AW'(to_out(yaw_z, PI_O));
    pr        = to_out(pitch_z, HPI_O);
    clamp_nxt = clf_r[CORDIC_STEPS][1] | clf_r[CORDIC_STEPS][0];
    priority if (clf_r[CORDIC_STEPS][1]) begin
      pitch_nxt = (AW-1)'(HPI_O);
    end else if (clf_r[CORDIC_STEPS][0]) begin
      pitch_nxt = -(AW-1)'(HPI_O);
    end else begin
      pitch_nxt = (AW-1)'(pr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  assign out_tvalid   = vld_r[LAT-1];
  assign out_tdata    = OW'({yaw_r, pitch_r, roll_r});
  assign out_tuser[0] = clamp_r;

  // a clamped pitch is exactly plus or minus a quarter turn
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && clamp_r |->
      (pitch_r == (AW-1)'(HPI_O)) || (pitch_r == -(AW-1)'(HPI_O)))
    else $error("clamped pitch is not a quarter turn");

  // an accepted word enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted word lost at pipeline entry");

  // the input stalls only behind a waiting output word
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

endmodule

### tb/tb.sv
// Testbench for quaternion_to_euler: drives quaternion words, predicts angles.
// Holds its own fixed-point predictor and a small scoreboard class.
// Depends on quaternion_to_euler (and q2e_pkg through it).
module tb;

  localparam int IW = 16;
  localparam int AW = 16;
  localparam int STEPS = 16;
  localparam int DW = ((4*IW+7)/8)*8;
  localparam int OW = ((3*AW-1+7)/8)*8;
  localparam int LATENCY = STEPS + 35;
  localparam int RANDOM_WORDS = 700;

  localparam longint HALF_PI_Q24 = 64'sd26353589;
  localparam longint PI_Q29v = 64'sd1686629713;
  localparam longint HALF_PI_Q29v = 64'sd843314857;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-2:0] pitch;
    logic signed [AW-1:0] yaw;
    logic                 clamped;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [DW-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OW-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  bit failed = 0;
  bit calm = 0;      // no idling in the last part
  bit hold_off = 0;  // long receiver stall requested

  longint atan_steps [0:15] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

  quaternion_to_euler uut (.*);

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint scaled_mul(longint a, longint b);
    return floor_shift(a * b, 2*(IW-2) - 28);
  endfunction

  function automatic longint int_root(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // vectoring-mode arctangent, angle in Q.24
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        z = HALF_PI_Q24; t = x; x = y; y = -t;
      end else begin
        z = -HALF_PI_Q24; t = x; x = -y; y = t;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_steps[i];
      end else begin
        x = x - ys; y = y + xs; z -= atan_steps[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_const(longint q29);
    return (q29 + (64'sd1 <<< (32-AW-1))) >>> (32-AW);
  endfunction

  function automatic longint angle_out(longint z, longint lim);
    longint r;
    int sh;
    sh = 24 - (AW-3);
    r = (z + (64'sd1 <<< (sh-1))) >>> sh;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(logic [DW-1:0] word);
    longint w, x, y, z, one, sr, cr, sy, cy, s, pi_o, hpi_o, c;
    angles_t a;
    w = longint'($signed(word[IW-1:0]));
    x = longint'($signed(word[2*IW-1:IW]));
    y = longint'($signed(word[3*IW-1:2*IW]));
    z = longint'($signed(word[4*IW-1:3*IW]));
    one = 64'sd1 <<< 28;
    pi_o = round_const(PI_Q29v);
    hpi_o = round_const(HALF_PI_Q29v);
    sr = 2 * (scaled_mul(w, x) + scaled_mul(y, z));
    cr = one - 2 * (scaled_mul(x, x) + scaled_mul(y, y));
    sy = 2 * (scaled_mul(w, z) + scaled_mul(x, y));
    cy = one - 2 * (scaled_mul(y, y) + scaled_mul(z, z));
    s = 2 * (scaled_mul(w, y) - scaled_mul(z, x));
    a.roll = AW'(angle_out(vector_angle(sr, cr), pi_o));
    a.yaw = AW'(angle_out(vector_angle(sy, cy), pi_o));
    if (s >= one) begin
      a.pitch = (AW-1)'(hpi_o); a.clamped = 1'b1;
    end else if (s <= -one) begin
      a.pitch = (AW-1)'(-hpi_o); a.clamped = 1'b1;
    end else begin
      c = int_root((64'sd1 <<< 56) - s * s);
      a.pitch = (AW-1)'(angle_out(vector_angle(s, c), hpi_o));
      a.clamped = 1'b0;
    end
    return a;
  endfunction

  class angle_board;
    angles_t pending[$];

    function void note_word(logic [DW-1:0] word);
      pending.push_back(euler_of(word));
    endfunction

    function void check_word(logic [OW-1:0] data, logic flag);
      angles_t e, g;
      g.roll = data[AW-1:0];
      g.pitch = data[2*AW-2:AW];
      g.yaw = data[3*AW-2:2*AW-1];
      g.clamped = flag;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        failed = 1;
        return;
      end
      e = pending.pop_front();
      if (g.roll !== e.roll) begin
        $error("roll_angle exp %0d got %0d", e.roll, g.roll); failed = 1;
      end
      if (g.pitch !== e.pitch) begin
        $error("pitch_angle exp %0d got %0d", e.pitch, g.pitch); failed = 1;
      end
      if (g.yaw !== e.yaw) begin
        $error("yaw_angle exp %0d got %0d", e.yaw, g.yaw); failed = 1;
      end
      if (g.clamped !== e.clamped) begin
        $error("pitch_clamped exp %0d got %0d", e.clamped, g.clamped); failed = 1;
      end
    endfunction
  endclass

  angle_board board = new();

  initial begin
    forever #10 clk = ~clk;
  end

  // monitor both handshakes
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_word(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata, out_tuser[0]);
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [DW-1:0] word);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
    in_tdata <= word;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pack_quat(int w, int x, int y, int z);
    logic [DW-1:0] d;
    d = '0;
    d[IW-1:0] = w[IW-1:0];
    d[2*IW-1:IW] = x[IW-1:0];
    d[3*IW-1:2*IW] = y[IW-1:0];
    d[4*IW-1:3*IW] = z[IW-1:0];
    return d;
  endfunction

  // near-unit quaternion with random direction
  function automatic logic [DW-1:0] unit_quat();
    real a, b, c, d, m;
    a = $urandom_range(0, 65535) - 32768.0;
    b = $urandom_range(0, 65535) - 32768.0;
    c = $urandom_range(0, 65535) - 32768.0;
    d = $urandom_range(0, 65535) - 32768.0;
    m = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
    return pack_quat(int'(a/m*16384.0), int'(b/m*16384.0),
                     int'(c/m*16384.0), int'(d/m*16384.0));
  endfunction

  initial begin
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: identity, axes, gimbal lock, zero, extremes
    send_word(pack_quat(16384, 0, 0, 0));
    send_word(pack_quat(0, 0, 0, 0));
    send_word(pack_quat(0, 16384, 0, 0));
    send_word(pack_quat(0, 0, 16384, 0));
    send_word(pack_quat(0, 0, 0, 16384));
    send_word(pack_quat(11585, 0, 11585, 0));
    send_word(pack_quat(11585, 0, -11585, 0));
    send_word(pack_quat(11585, 11585, 0, 0));
    send_word(pack_quat(11585, 0, 0, -11585));
    send_word(pack_quat(8192, 8192, 8192, 8192));
    send_word(pack_quat(8192, -8192, 8192, 8192));
    send_word(pack_quat(32767, 32767, 32767, 32767));
    send_word(pack_quat(-32768, -32768, -32768, -32768));
    send_word(pack_quat(32767, -32768, 32767, -32768));
    send_word(pack_quat(-32768, 0, 32767, 0));
    send_word(pack_quat(0, 23170, 0, 0));
    send_word(pack_quat(-1, -1, -1, -1));
    send_word(pack_quat(1, 1, 1, 1));
    // random: mostly unit quaternions, some raw patterns
    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k == 200) hold_off = 1;
      if (k == RANDOM_WORDS - 100) calm = 1;
      if ($urandom_range(0, 3) == 0)
        send_word(pack_quat($urandom, $urandom, $urandom, $urandom));
      else
        send_word(unit_quat());
    end
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (failed || board.pending.size() != 0)
      $display("Verification failed");
    else
      $display("Verification passed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
